// ----- rtl/clcd_pkg.sv -----
`default_nettype none

package clcd_pkg;

    localparam int COLUMNS = 20;

    localparam int STEP_W = 4;
    localparam int TIMER_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 2;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_INIT   = 3'd1;
    localparam logic [2:0] OP_CMD    = 3'd2;
    localparam logic [2:0] OP_CHAR   = 3'd3;
    localparam logic [2:0] OP_CURSOR = 3'd4;

    localparam logic [CFG_ADDR_W-1:0] REG_ENABLE_HIGH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SETTLE      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_WAIT   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_POWER_UP    = 2'd3;

    localparam logic [7:0]  ENABLE_HIGH_RESET = 8'd1;
    localparam logic [9:0]  SETTLE_RESET      = 10'd50;
    localparam logic [15:0] LONG_WAIT_RESET   = 16'd2000;
    localparam logic [15:0] POWER_UP_RESET    = 16'd50000;

    localparam logic [TIMER_W-1:0] WAIT_FIRST  = 16'd5000;
    localparam logic [TIMER_W-1:0] WAIT_SECOND = 16'd150;

    localparam logic [3:0] NIB_THREE = 4'h3;
    localparam logic [3:0] NIB_TWO   = 4'h2;

    localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_HOME         = 8'h02;
    localparam logic [7:0] CMD_SET_DDRAM    = 8'h80;

    localparam logic [6:0] ROW1_BASE = 7'h40;
    localparam logic [6:0] ROW2_BASE = 7'(COLUMNS);
    localparam logic [6:0] ROW3_BASE = 7'(8'h40 + COLUMNS);
    localparam logic [5:0] COL_MAX   = 6'(COLUMNS - 1);
    localparam logic [2:0] ROW_MAX   = 3'd3;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] value;
        logic [5:0] column;
        logic [2:0] row;
    } in_item_t;

    typedef struct packed {
        logic       rs_pin;
        logic       enable_pin;
        logic [3:0] data_nibble;
        logic       busy_res;
        logic       rejected;
    } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/char_lcd_4bit_interface_sequencer_unit.sv -----
`default_nettype none

// Four-bit character LCD sequencer. Each transfer on the s_ channel is either a
// one-microsecond tick or a request (initialize, command byte, character byte,
// set cursor), and each yields exactly one result transfer on the m_ channel
// carrying the RS, E and D7..D4 levels and the busy and rejected flags after
// that item. The sequencer state and the result are computed in the cycle an
// item is accepted; the result goes to the output register, or to the skid
// register while the output waits. Together they hold up to two results, so
// s_ready only drops when both are full. The four timing registers are
// written through the cfg_ port and should only change while the block is idle.
module char_lcd_4bit_interface_sequencer_unit
    import clcd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_item,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_item
);

    localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] ST_POWER = 4'd1;
    localparam logic [STEP_W-1:0] ST_N3A   = 4'd2;
    localparam logic [STEP_W-1:0] ST_W5000 = 4'd3;
    localparam logic [STEP_W-1:0] ST_N3B   = 4'd4;
    localparam logic [STEP_W-1:0] ST_W150  = 4'd5;
    localparam logic [STEP_W-1:0] ST_N3C   = 4'd6;
    localparam logic [STEP_W-1:0] ST_N2    = 4'd7;
    localparam logic [STEP_W-1:0] ST_B28   = 4'd8;
    localparam logic [STEP_W-1:0] ST_B0C   = 4'd9;
    localparam logic [STEP_W-1:0] ST_B06   = 4'd10;
    localparam logic [STEP_W-1:0] ST_B01   = 4'd11;
    localparam logic [STEP_W-1:0] ST_BYTE  = 4'd12;
    localparam logic [STEP_W-1:0] ST_LONG  = 4'd13;

    logic [7:0]         enable_high_reg;
    logic [9:0]         settle_reg;
    logic [15:0]        long_wait_reg;
    logic [15:0]        power_up_reg;

    logic [STEP_W-1:0]  step_reg, step_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [7:0]         pend_reg, pend_next;
    logic               rs_reg, rs_next;
    logic               en_reg, en_next;
    logic [3:0]         nib_reg, nib_next;
    logic               low_reg, low_next;
    logic               rej;

    out_item_t          out_reg, skid_reg, result;
    logic               out_valid_reg, skid_valid_reg;

    logic               accept;
    logic               pop;

    assign accept  = s_valid && s_ready;
    assign pop     = m_valid && m_ready;
    assign s_ready = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_high_reg <= ENABLE_HIGH_RESET;
            settle_reg      <= SETTLE_RESET;
            long_wait_reg   <= LONG_WAIT_RESET;
            power_up_reg    <= POWER_UP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_ENABLE_HIGH: enable_high_reg <= cfg_wdata[7:0];
                REG_SETTLE:      settle_reg      <= cfg_wdata[9:0];
                REG_LONG_WAIT:   long_wait_reg   <= cfg_wdata;
                REG_POWER_UP:    power_up_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic              do_enter;
        logic [STEP_W-1:0] target;
        logic [7:0]        byte_val;
        logic [2:0]        row_c;
        logic [5:0]        col_c;
        logic [6:0]        base;
        logic [6:0]        addr;

        step_next  = step_reg;
        timer_next = timer_reg;
        pend_next  = pend_reg;
        rs_next    = rs_reg;
        en_next    = en_reg;
        nib_next   = nib_reg;
        low_next   = low_reg;
        rej        = 1'b0;
        do_enter   = 1'b0;
        target     = ST_IDLE;
        byte_val   = s_item.value;
        row_c      = (s_item.row > ROW_MAX) ? ROW_MAX : s_item.row;
        col_c      = (s_item.column > COL_MAX) ? COL_MAX : s_item.column;

        case (row_c[1:0])
            2'd0:    base = 7'd0;
            2'd1:    base = ROW1_BASE;
            2'd2:    base = ROW2_BASE;
            default: base = ROW3_BASE;
        endcase
        addr = base + {1'b0, col_c};

        unique case (s_item.op)
            OP_TICK: begin
                unique case (step_reg)
                    ST_IDLE: ;
                    ST_N3A, ST_N3B, ST_N3C, ST_N2,
                    ST_B28, ST_B0C, ST_B06, ST_B01, ST_BYTE: begin
                        if (timer_reg > TIMER_W'(1)) begin
                            timer_next = timer_reg - TIMER_W'(1);
                        end else if (en_reg) begin
                            en_next    = 1'b0;
                            timer_next = TIMER_W'(settle_reg);
                        end else if (step_reg >= ST_B28) begin
                            if (!low_reg) begin
                                low_next   = 1'b1;
                                nib_next   = pend_reg[3:0];
                                en_next    = 1'b1;
                                timer_next = TIMER_W'(enable_high_reg);
                            end else begin
                                low_next = 1'b0;
                                do_enter = 1'b1;
                                if (!rs_reg && (pend_reg == CMD_CLEAR ||
                                                pend_reg == CMD_HOME)) begin
                                    target = ST_LONG;
                                end else if (step_reg == ST_BYTE) begin
                                    target = ST_IDLE;
                                end else begin
                                    target = step_reg + STEP_W'(1);
                                end
                            end
                        end else begin
                            do_enter = 1'b1;
                            target   = step_reg + STEP_W'(1);
                        end
                    end
                    ST_POWER, ST_W5000, ST_W150, ST_LONG: begin
                        if (timer_reg > TIMER_W'(1)) begin
                            timer_next = timer_reg - TIMER_W'(1);
                        end else begin
                            do_enter = 1'b1;
                            target   = (step_reg == ST_LONG) ? ST_IDLE
                                                             : step_reg + STEP_W'(1);
                        end
                    end
                    default: begin
                        do_enter = 1'b1;
                        target   = ST_IDLE;
                    end
                endcase
            end
            OP_INIT, OP_CMD, OP_CHAR, OP_CURSOR: begin
                if (step_reg != ST_IDLE) begin
                    rej = 1'b1;
                end else if (s_item.op == OP_INIT) begin
                    rs_next  = 1'b0;
                    en_next  = 1'b0;
                    low_next = 1'b0;
                    do_enter = 1'b1;
                    target   = ST_POWER;
                end else begin
                    rs_next = (s_item.op == OP_CHAR);
                    if (s_item.op == OP_CURSOR) begin
                        byte_val = CMD_SET_DDRAM | {1'b0, addr};
                    end
                    step_next  = ST_BYTE;
                    pend_next  = byte_val;
                    low_next   = 1'b0;
                    nib_next   = byte_val[7:4];
                    en_next    = 1'b1;
                    timer_next = TIMER_W'(enable_high_reg);
                end
            end
            default: rej = 1'b1;
        endcase

        if (do_enter) begin
            step_next = target;
            unique case (target)
                ST_POWER: timer_next = power_up_reg;
                ST_N3A, ST_N3B, ST_N3C: begin
                    nib_next   = NIB_THREE;
                    en_next    = 1'b1;
                    timer_next = TIMER_W'(enable_high_reg);
                end
                ST_N2: begin
                    nib_next   = NIB_TWO;
                    en_next    = 1'b1;
                    timer_next = TIMER_W'(enable_high_reg);
                end
                ST_W5000: timer_next = WAIT_FIRST;
                ST_W150:  timer_next = WAIT_SECOND;
                ST_B28, ST_B0C, ST_B06, ST_B01: begin
                    case (target)
                        ST_B28:  pend_next = CMD_FUNCTION_SET;
                        ST_B0C:  pend_next = CMD_DISPLAY_ON;
                        ST_B06:  pend_next = CMD_ENTRY_MODE;
                        default: pend_next = CMD_CLEAR;
                    endcase
                    low_next   = 1'b0;
                    nib_next   = pend_next[7:4];
                    en_next    = 1'b1;
                    timer_next = TIMER_W'(enable_high_reg);
                end
                ST_LONG: timer_next = long_wait_reg;
                default: begin
                    step_next  = ST_IDLE;
                    timer_next = '0;
                end
            endcase
        end

        result.rs_pin      = rs_next;
        result.enable_pin  = en_next;
        result.data_nibble = nib_next;
        result.busy_res    = (step_next != ST_IDLE);
        result.rejected    = rej;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= ST_IDLE;
            timer_reg <= '0;
            pend_reg  <= '0;
            rs_reg    <= 1'b0;
            en_reg    <= 1'b0;
            nib_reg   <= '0;
            low_reg   <= 1'b0;
        end else if (accept) begin
            step_reg  <= step_next;
            timer_reg <= timer_next;
            pend_reg  <= pend_next;
            rs_reg    <= rs_next;
            en_reg    <= en_next;
            nib_reg   <= nib_next;
            low_reg   <= low_next;
        end
    end

    // The skid register catches a result when the output register is still
    // waiting for its transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (accept) begin
            if (!out_valid_reg || pop) begin
                out_reg <= result;
            end else begin
                skid_reg <= result;
            end
        end
    end

endmodule

`default_nettype wire
